// ----- hw/rtl/mtsf_pkg.sv -----
// Package with constants and helper functions of the markup tag strip filter.
package mtsf_pkg;

    localparam int TAG_MAX_DEF = 60;
    localparam int PREFIX_LEN  = 20;
    localparam int PFX_IW      = 5;

    localparam logic [7:0] CH_SP = 8'h20;
    localparam logic [7:0] CH_LT = 8'h3C;
    localparam logic [7:0] CH_GT = 8'h3E;

    // The sync prefix, already folded to lower case.
    function automatic logic [7:0] prefix_byte(input logic [PFX_IW-1:0] idx);
        logic [7:0] b;
        case (idx)
            5'd0:    b = "s";
            5'd1:    b = "y";
            5'd2:    b = "n";
            5'd3:    b = "c";
            5'd4:    b = " ";
            5'd5:    b = "t";
            5'd6:    b = "y";
            5'd7:    b = "p";
            5'd8:    b = "e";
            5'd9:    b = "=";
            5'd10:   b = 8'h22;
            5'd11:   b = "s";
            5'd12:   b = "t";
            5'd13:   b = "r";
            5'd14:   b = "o";
            5'd15:   b = "n";
            5'd16:   b = "g";
            5'd17:   b = "s";
            5'd18:   b = 8'h22;
            5'd19:   b = " ";
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c inside {[8'h41:8'h5A]}) begin
            r = c + 8'd32;
        end
        return r;
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return c inside {8'h20, 8'h2C, 8'h3B, 8'h2E, 8'h3F, 8'h21, 8'h29, 8'h27, 8'h22};
    endfunction

endpackage

// ----- hw/rtl/markup_tag_strip_filter.sv -----
// Top level of the markup tag strip filter: tag buffer, replay sequencer and output register.
//
//  channel | direction | handshake                 | payload
//  in      | input     | i_in_valid / o_in_ready   | i_in_char, i_in_last
//  out     | output    | o_out_valid / i_out_ready | o_out_char, o_char_valid, o_run_last,
//          |           |                           | o_text_end
//  cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_data (show_tags)
//
// A byte inside a tag that is not the last causes no result, and the block is ready again
// in the next cycle. Otherwise each result is a step of the sequencer, and no new byte is
// taken until the last step is done: a held space may go out with a plain byte, and a kept
// tag goes out as <, its N buffered bytes and >, after any held space.
// Replayed tag bytes come from the single tag buffer read port, one per cycle when not stalled.
// Reset is synchronous and active low; the tag buffer is not cleared.
// A stall on the output holds the sequencer in its step until the output register drains.
module markup_tag_strip_filter #(
    parameter int TAG_MAX = mtsf_pkg::TAG_MAX_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_char,
    input  logic       i_in_last,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_char,
    output logic       o_char_valid,
    output logic       o_run_last,
    output logic       o_text_end,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_data
);

    localparam int AW = $clog2(TAG_MAX);
    localparam int LW = $clog2(TAG_MAX + 1);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_PRE  = 8'b0000_0010,
        S_LT   = 8'b0000_0100,
        S_BUF  = 8'b0000_1000,
        S_GT   = 8'b0001_0000,
        S_CHR  = 8'b0010_0000,
        S_POST = 8'b0100_0000,
        S_BARE = 8'b1000_0000
    } t_state;

    function automatic t_state next_step(input logic [6:0] plan);
        logic [6:0] low;
        low = plan & (~plan + 7'd1);
        return (plan == 7'd0) ? S_IDLE : t_state'({low, 1'b0});
    endfunction

    t_state      r_state, n_state;
    logic [6:0]  r_plan, n_plan;
    logic        r_end, n_end;
    logic        r_show;
    logic        r_in_tag, n_in_tag;
    logic [LW-1:0] r_tag_len, n_tag_len;
    logic        r_pm, n_pm;
    logic        r_held, n_held;
    logic        r_ad, n_ad;
    logic [LW-1:0] r_idx, n_idx;
    logic [LW-1:0] r_rep_len, n_rep_len;
    logic [7:0]  r_char, n_char;
    logic [7:0]  r_rd_data;
    logic [7:0]  r_mem [TAG_MAX];
    logic        r_ov, n_ov;
    logic [7:0]  r_oc, n_oc;
    logic        r_ocv, n_ocv;
    logic        r_orl, n_orl;
    logic        r_ote, n_ote;

    logic        accept;
    logic        slot_free;
    logic        wr_en;
    logic [AW-1:0] rd_addr;
    logic [6:0]  rem;
    logic        p_pre, p_tag, p_chr, held_a, match;
    logic [7:0]  e_char;
    logic        e_cv;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign accept      = i_in_valid && o_in_ready;
    assign slot_free   = !r_ov || i_out_ready;
    assign wr_en       = accept && (i_in_char != mtsf_pkg::CH_LT) && r_in_tag
                         && (i_in_char != mtsf_pkg::CH_GT) && (r_tag_len < LW'(TAG_MAX));
    assign match       = r_pm && (r_tag_len >= LW'(mtsf_pkg::PREFIX_LEN));

    always_comb begin
        n_state   = r_state;
        n_plan    = r_plan;
        n_end     = r_end;
        n_in_tag  = r_in_tag;
        n_tag_len = r_tag_len;
        n_pm      = r_pm;
        n_held    = r_held;
        n_ad      = r_ad;
        n_idx     = r_idx;
        n_rep_len = r_rep_len;
        n_char    = r_char;
        n_ov      = r_ov && !i_out_ready;
        n_oc      = r_oc;
        n_ocv     = r_ocv;
        n_orl     = r_orl;
        n_ote     = r_ote;
        rem       = 7'd0;
        p_pre     = 1'b0;
        p_tag     = 1'b0;
        p_chr     = 1'b0;
        held_a    = r_held;
        e_char    = 8'h00;
        e_cv      = 1'b1;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_in_char == mtsf_pkg::CH_LT) begin
                        n_in_tag  = 1'b1;
                        n_tag_len = '0;
                        n_pm      = 1'b1;
                        n_ad      = 1'b0;
                    end else if (r_in_tag && i_in_char == mtsf_pkg::CH_GT) begin
                        n_in_tag = 1'b0;
                        if (match && !r_show) begin
                            n_ad = 1'b1;
                        end else begin
                            p_pre     = r_held;
                            held_a    = 1'b0;
                            n_ad      = 1'b0;
                            p_tag     = 1'b1;
                            n_rep_len = r_tag_len;
                        end
                    end else if (r_in_tag) begin
                        if (r_tag_len < LW'(TAG_MAX)) begin
                            if (r_tag_len < LW'(mtsf_pkg::PREFIX_LEN) &&
                                mtsf_pkg::fold_case(i_in_char) !=
                                mtsf_pkg::prefix_byte(r_tag_len[mtsf_pkg::PFX_IW-1:0])) begin
                                n_pm = 1'b0;
                            end
                            n_tag_len = r_tag_len + LW'(1);
                        end
                    end else begin
                        p_pre  = r_held && !(r_ad && mtsf_pkg::is_punct(i_in_char));
                        n_ad   = 1'b0;
                        held_a = (i_in_char == mtsf_pkg::CH_SP);
                        p_chr  = !held_a;
                        n_char = i_in_char;
                    end
                    n_held = held_a;
                    rem = {1'b0, i_in_last && held_a, p_chr, p_tag, p_tag && n_rep_len != '0,
                           p_tag, p_pre};
                    if (i_in_last) begin
                        n_in_tag  = 1'b0;
                        n_tag_len = '0;
                        n_pm      = 1'b1;
                        n_held    = 1'b0;
                        n_ad      = 1'b0;
                        if (rem == 7'd0) begin
                            rem = 7'b100_0000;
                        end
                    end
                    n_plan  = rem;
                    n_end   = i_in_last;
                    n_state = next_step(rem);
                end
            end
            default: begin
                case (r_state)
                    S_PRE:  e_char = mtsf_pkg::CH_SP;
                    S_LT:   e_char = mtsf_pkg::CH_LT;
                    S_BUF:  e_char = r_rd_data;
                    S_GT:   e_char = mtsf_pkg::CH_GT;
                    S_CHR:  e_char = r_char;
                    S_POST: e_char = mtsf_pkg::CH_SP;
                    default: begin
                        e_char = 8'h00;
                        e_cv   = 1'b0;
                    end
                endcase
                if (r_state == S_BUF && r_idx + LW'(1) != r_rep_len) begin
                    rem = r_plan;
                end else begin
                    rem = r_plan & ~r_state[7:1];
                end
                if (slot_free) begin
                    n_ov    = 1'b1;
                    n_oc    = e_char;
                    n_ocv   = e_cv;
                    n_orl   = (rem == 7'd0);
                    n_ote   = (rem == 7'd0) && r_end;
                    n_plan  = rem;
                    n_state = next_step(rem);
                    if (r_state == S_LT) begin
                        n_idx = '0;
                    end else if (r_state == S_BUF) begin
                        n_idx = r_idx + LW'(1);
                    end
                end
            end
        endcase
    end

    assign rd_addr = (n_idx < LW'(TAG_MAX)) ? n_idx[AW-1:0] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_plan    <= '0;
            r_end     <= 1'b0;
            r_show    <= 1'b0;
            r_in_tag  <= 1'b0;
            r_tag_len <= '0;
            r_pm      <= 1'b1;
            r_held    <= 1'b0;
            r_ad      <= 1'b0;
            r_idx     <= '0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_plan    <= n_plan;
            r_end     <= n_end;
            r_in_tag  <= n_in_tag;
            r_tag_len <= n_tag_len;
            r_pm      <= n_pm;
            r_held    <= n_held;
            r_ad      <= n_ad;
            r_idx     <= n_idx;
            r_ov      <= n_ov;
            if (i_cfg_valid && o_cfg_ready) begin
                r_show <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rep_len <= n_rep_len;
        r_char    <= n_char;
        r_oc      <= n_oc;
        r_ocv     <= n_ocv;
        r_orl     <= n_orl;
        r_ote     <= n_ote;
        if (wr_en) begin
            r_mem[r_tag_len[AW-1:0]] <= i_in_char;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    assign o_out_valid  = r_ov;
    assign o_out_char   = r_oc;
    assign o_char_valid = r_ocv;
    assign o_run_last   = r_orl;
    assign o_text_end   = r_ote;

endmodule

// ----- sim/markup_tag_strip_filter_chk.sv -----
`timescale 1ns / 100ps
// Checker that predicts the filtered byte stream and compares it with the block's results.
module markup_tag_strip_filter_chk #(
    parameter int TAG_MAX = mtsf_pkg::TAG_MAX_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_in_char,
    input  logic       i_in_last,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_out_char,
    input  logic       i_char_valid,
    input  logic       i_run_last,
    input  logic       i_text_end,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic       i_cfg_data,
    output int         o_fail_count,
    output int         o_pending
);

    localparam int SYNC_LEN   = 20;
    localparam int MAX_SHOWN  = 10;
    localparam logic [8*SYNC_LEN-1:0] SYNC_LC = "sync type=\"strongs\" ";

    typedef struct packed {
        logic [7:0] ch;
        logic       cv;
        logic       rl;
        logic       te;
    } t_filt_rec;

    logic       show_tags;
    logic       in_tag;
    logic [7:0] tag_buf [0:TAG_MAX-1];
    int         tag_len;
    logic       pfx_ok;
    logic       held_sp;
    logic       after_drop;
    t_filt_rec  filtered_q [$];
    int         err_cnt = 0;

    function automatic logic [7:0] lower_ascii(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic logic eats_space(input logic [7:0] c);
        case (c)
            " ", ",", ";", ".", "?", "!", ")", "'", 8'h22: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic t_filt_rec glyph(input logic [7:0] c);
        return {c, 1'b1, 2'b00};
    endfunction

    task automatic clear_text();
        in_tag     = 1'b0;
        tag_len    = 0;
        pfx_ok     = 1'b1;
        held_sp    = 1'b0;
        after_drop = 1'b0;
    endtask

    task automatic filter_byte(input logic [7:0] c, input logic last);
        t_filt_rec res [0:63];
        int        n;
        int        i;
        logic      hit;
        n = 0;
        if (c == mtsf_pkg::CH_LT) begin
            in_tag     = 1'b1;
            tag_len    = 0;
            pfx_ok     = 1'b1;
            after_drop = 1'b0;
        end else if (in_tag && c == mtsf_pkg::CH_GT) begin
            hit    = pfx_ok && tag_len >= SYNC_LEN;
            in_tag = 1'b0;
            if (hit && !show_tags) begin
                after_drop = 1'b1;
            end else begin
                if (held_sp) begin
                    res[n] = glyph(mtsf_pkg::CH_SP);
                    n++;
                end
                held_sp    = 1'b0;
                after_drop = 1'b0;
                res[n] = glyph(mtsf_pkg::CH_LT);
                n++;
                for (i = 0; i < tag_len; i++) begin
                    res[n] = glyph(tag_buf[i]);
                    n++;
                end
                res[n] = glyph(mtsf_pkg::CH_GT);
                n++;
            end
        end else if (in_tag) begin
            if (tag_len < TAG_MAX) begin
                if (tag_len < SYNC_LEN &&
                    lower_ascii(c) != SYNC_LC[8*(SYNC_LEN-1-tag_len) +: 8]) begin
                    pfx_ok = 1'b0;
                end
                tag_buf[tag_len] = c;
                tag_len++;
            end
        end else begin
            if (held_sp) begin
                if (!(after_drop && eats_space(c))) begin
                    res[n] = glyph(mtsf_pkg::CH_SP);
                    n++;
                end
                held_sp = 1'b0;
            end
            after_drop = 1'b0;
            if (c == mtsf_pkg::CH_SP) begin
                held_sp = 1'b1;
            end else begin
                res[n] = glyph(c);
                n++;
            end
        end

        if (last) begin
            if (held_sp) begin
                res[n] = glyph(mtsf_pkg::CH_SP);
                n++;
            end
            clear_text();
            if (n == 0) begin
                res[0] = '0;
                n = 1;
            end
            res[n-1].te = 1'b1;
        end
        if (n > 0) begin
            res[n-1].rl = 1'b1;
        end
        for (i = 0; i < n; i++) begin
            filtered_q.push_back(res[i]);
        end
    endtask

    task automatic check_result();
        t_filt_rec want;
        if (filtered_q.size() == 0) begin
            err_cnt++;
            if (err_cnt <= MAX_SHOWN) begin
                $display("[%0t] unexpected result: char %h valid %b run_last %b end %b",
                         $time, i_out_char, i_char_valid, i_run_last, i_text_end);
            end
        end else begin
            want = filtered_q.pop_front();
            if (want.ch != i_out_char || want.cv != i_char_valid ||
                want.rl != i_run_last || want.te != i_text_end) begin
                err_cnt++;
                if (err_cnt <= MAX_SHOWN) begin
                    $display("[%0t] mismatch: expected char %h valid %b run_last %b end %b",
                             $time, want.ch, want.cv, want.rl, want.te);
                    $display("[%0t]           actual char %h valid %b run_last %b end %b",
                             $time, i_out_char, i_char_valid, i_run_last, i_text_end);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            show_tags = 1'b0;
            clear_text();
            filtered_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                show_tags = i_cfg_data;
            end
            if (i_in_valid && i_in_ready) begin
                filter_byte(i_in_char, i_in_last);
            end
            if (i_out_valid && i_out_ready) begin
                check_result();
            end
        end
        o_fail_count <= err_cnt;
        o_pending    <= filtered_q.size();
    end

endmodule

// ----- sim/markup_tag_strip_filter_tb.sv -----
`timescale 1ns / 100ps
// Testbench top that drives text and configuration into the markup tag strip filter.
module markup_tag_strip_filter_tb;

    localparam int SETTLE_CYC  = 70;
    localparam int QUIET_LIMIT = 3000;
    localparam int PREFIX_LEN  = mtsf_pkg::PREFIX_LEN;

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       in_valid   = 1'b0;
    logic       in_ready;
    logic [7:0] in_char    = 8'h00;
    logic       in_last    = 1'b0;
    logic       out_valid;
    logic       out_ready  = 1'b0;
    logic [7:0] out_char;
    logic       char_valid;
    logic       run_last;
    logic       text_end;
    logic       cfg_valid  = 1'b0;
    logic       cfg_ready;
    logic       cfg_data   = 1'b0;

    int fail_count;
    int pending;
    int send_idle  = 0;
    int recv_stall = 0;
    int items_sent = 0;
    int quiet      = 0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    markup_tag_strip_filter u_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_in_char    (in_char),
        .i_in_last    (in_last),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_out_char   (out_char),
        .o_char_valid (char_valid),
        .o_run_last   (run_last),
        .o_text_end   (text_end),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data)
    );

    markup_tag_strip_filter_chk u_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_char    (in_char),
        .i_in_last    (in_last),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_char   (out_char),
        .i_char_valid (char_valid),
        .i_run_last   (run_last),
        .i_text_end   (text_end),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_stall);
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
        end
        if (quiet >= QUIET_LIMIT) begin
            $display("** markup_tag_strip_filter: FAILED **");
            $finish;
        end
    end

    function automatic logic [7:0] any_letter();
        return $urandom_range(1) ? 8'($urandom_range("z", "a")) : 8'($urandom_range("Z", "A"));
    endfunction

    function automatic logic [7:0] stop_char();
        case ($urandom_range(8))
            0:       return " ";
            1:       return ",";
            2:       return ";";
            3:       return ".";
            4:       return "?";
            5:       return "!";
            6:       return ")";
            7:       return "'";
            default: return 8'h22;
        endcase
    endfunction

    function automatic logic [7:0] tag_fill();
        logic [7:0] b;
        b = $urandom_range(1) ? 8'($urandom_range(126, 32)) : 8'($urandom);
        if (b == mtsf_pkg::CH_LT || b == mtsf_pkg::CH_GT) begin
            b = "x";
        end
        return b;
    endfunction

    // Holds the request until the block takes it; valid stays high for a following byte.
    task automatic send_byte(input logic [7:0] c, input logic last);
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_char  <= c;
        in_last  <= last;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    task automatic send_sync_tag(input int extra, input logic spoil);
        logic [7:0] b;
        int         spoil_at;
        int         stop_at;
        int         i;
        spoil_at = spoil ? $urandom_range(PREFIX_LEN - 1) : -1;
        stop_at  = (spoil && $urandom_range(1)) ? spoil_at : PREFIX_LEN;
        send_byte(mtsf_pkg::CH_LT, 1'b0);
        for (i = 0; i < stop_at; i++) begin
            b = mtsf_pkg::prefix_byte(5'(i));
            if (b >= "a" && b <= "z" && $urandom_range(1)) begin
                b = b - 8'd32;
            end
            if (i == spoil_at) begin
                b = b ^ 8'h01;
            end
            send_byte(b, 1'b0);
        end
        for (i = 0; i < extra; i++) begin
            send_byte(tag_fill(), 1'b0);
        end
        send_byte(mtsf_pkg::CH_GT, 1'b0);
    endtask

    task automatic send_plain_tag(input int len);
        int i;
        send_byte(mtsf_pkg::CH_LT, 1'b0);
        for (i = 0; i < len; i++) begin
            send_byte(tag_fill(), 1'b0);
        end
        send_byte(mtsf_pkg::CH_GT, 1'b0);
    endtask

    task automatic send_text(input int budget);
        int start;
        int k;
        int n;
        int i;
        start = items_sent;
        while (items_sent - start < budget) begin
            k = $urandom_range(99);
            if (k < 25) begin
                n = $urandom_range(4, 1);
                for (i = 0; i < n; i++) begin
                    send_byte(any_letter(), 1'b0);
                end
            end else if (k < 38) begin
                send_byte(mtsf_pkg::CH_SP, 1'b0);
            end else if (k < 62) begin
                send_byte(mtsf_pkg::CH_SP, 1'b0);
                send_sync_tag($urandom_range(4), $urandom_range(4) == 0);
                if ($urandom_range(1)) begin
                    send_sync_tag($urandom_range(3), $urandom_range(4) == 0);
                end
                send_byte($urandom_range(3) == 0 ? any_letter() : stop_char(), 1'b0);
            end else if (k < 72) begin
                send_byte(stop_char(), 1'b0);
            end else if (k < 82) begin
                send_plain_tag($urandom_range(8));
            end else if (k < 87) begin
                send_byte(mtsf_pkg::CH_LT, 1'b0);
                n = $urandom_range(3, 1);
                for (i = 0; i < n; i++) begin
                    send_byte(tag_fill(), 1'b0);
                end
                send_sync_tag($urandom_range(3), 1'b0);
            end else if (k < 91) begin
                send_byte(mtsf_pkg::CH_GT, 1'b0);
            end else if (k < 98) begin
                send_byte(8'($urandom), 1'b0);
            end else begin
                send_sync_tag($urandom_range(45, 38), 1'b0);
            end
        end
        case ($urandom_range(5))
            0:       send_byte(any_letter(), 1'b1);
            1:       send_byte(mtsf_pkg::CH_SP, 1'b1);
            2:       send_byte(".", 1'b1);
            3:       send_byte(mtsf_pkg::CH_LT, 1'b1);
            4:       send_byte(mtsf_pkg::CH_GT, 1'b1);
            default: send_byte(8'($urandom), 1'b1);
        endcase
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_show_tags(input logic v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_texts(input int quota);
        int start;
        start = items_sent;
        while (items_sent - start < quota) begin
            send_text($urandom_range(30, 8));
        end
        settle();
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle  = 24;
        recv_stall = 86;
        write_show_tags(1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(mtsf_pkg::CH_GT, 1'b0);
        send_byte(mtsf_pkg::CH_SP, 1'b0);
        send_byte(mtsf_pkg::CH_LT, 1'b0);
        send_byte("a", 1'b0);
        send_byte(mtsf_pkg::CH_LT, 1'b0);
        send_byte("b", 1'b0);
        send_byte(mtsf_pkg::CH_GT, 1'b0);
        send_byte(mtsf_pkg::CH_SP, 1'b1);
        send_byte(mtsf_pkg::CH_LT, 1'b1);
        send_byte("x", 1'b1);
        settle();

        write_show_tags(1'b1);
        send_byte("a", 1'b0);
        send_byte(mtsf_pkg::CH_SP, 1'b0);
        send_sync_tag(44, 1'b0);
        send_byte(".", 1'b1);
        run_texts(10);

        send_idle  = 86;
        recv_stall = 24;
        write_show_tags(1'b0);
        run_texts(55);

        send_idle  = 0;
        recv_stall = 0;
        write_show_tags(1'($urandom_range(1)));
        run_texts(45);

        if (fail_count == 0) begin
            $display("** markup_tag_strip_filter: PASSED **");
        end else begin
            $display("** markup_tag_strip_filter: FAILED **");
        end
        $finish;
    end

endmodule
